// ===== hdl/ocbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ocbs_pkg - shared types and tables of the OLED command byte sequencer
// Request and result payloads, the request descriptor passed from the front
// end to the back end, operation codes, the init table and the 5x8 font.
// ----------------------------------------------------------------------------
package ocbs_pkg;

	// Default values of the top level parameters
	localparam int INIT_LENGTH_DEF = 15;
	localparam int CLEAR_BYTES_DEF = 512;
	localparam int GLYPH_COUNT_DEF = 64;

	// Fixed sizes of the built-in tables and the descriptor queue
	localparam int INIT_TABLE_SIZE = 32;
	localparam int FONT_SIZE       = 64;
	localparam int QUEUE_DEPTH     = 2;
	localparam int STEP_W          = 6;

	// Request operation codes
	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_SHIFT  = 3'd1;
	localparam logic [2:0] OP_PRINT  = 3'd2;
	localparam logic [2:0] OP_CURSOR = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_COMMAND_PREFIX = 2'd1;
	localparam logic [1:0] REG_DATA_PREFIX    = 2'd2;

	// Controller command bytes
	localparam logic [7:0] CMD_SET_OFFSET = 8'hD3;
	localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
	localparam logic [7:0] CMD_COL_HI     = 8'h10;
	localparam logic [7:0] COL_LO_MASK    = 8'h0F;

	typedef enum logic [2:0] {
		KIND_INIT,
		KIND_SHIFT,
		KIND_PRINT,
		KIND_CURSOR,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] char_code;
		logic [6:0] column;
		logic [2:0] page;
		logic [5:0] vertical_shift;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       start_before;
		logic       stop_after;
		logic [9:0] repeat_count;
		logic       last;
	} rsp_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] glyph;
		logic [6:0] column;
		logic [2:0] page;
		logic [5:0] vshift;
	} desc_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] command_prefix;
		logic [7:0] data_prefix;
	} cfg_t;

	// Power-up command list; entries past the defined ones are zero
	localparam logic [7:0] INIT_TABLE [INIT_TABLE_SIZE] = '{
		8'hA8, 8'h1F, 8'h22, 8'h00, 8'h03, 8'h20, 8'h00, 8'hDA,
		8'h02, 8'h8D, 8'h14, 8'hAF, 8'hA1, 8'hC8, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Font glyphs for codes 32 to 95, first column in the top byte
	localparam logic [39:0] FONT [FONT_SIZE] = '{
		40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h6264081323, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
		40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040
	};

	// Pick one column of a glyph
	function automatic logic [7:0] font_column(input logic [5:0] glyph, input logic [2:0] col);
		logic [39:0] row;
		row = FONT[glyph];
		case (col)
			3'd0: font_column = row[39:32];
			3'd1: font_column = row[31:24];
			3'd2: font_column = row[23:16];
			3'd3: font_column = row[15:8];
			3'd4: font_column = row[7:0];
			default: font_column = 8'h00;
		endcase
	endfunction

endpackage

// ===== hdl/ocbs_stream_if.sv =====
// ----------------------------------------------------------------------------
// ocbs_stream_if - valid/ready stream channel
// Carries one payload item per handshake; source drives valid and data,
// sink drives ready.
// ----------------------------------------------------------------------------
interface ocbs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/oled_command_byte_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// oled_command_byte_sequencer_top - OLED command byte sequencer
// Expands display requests into the byte stream for a two-wire OLED link.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request items (operation, char_code, column, page, vertical_shift).
//   rsp  : result items, one bus byte each with start/stop marks, a repeat
//          count and a last flag on the final byte of a request.
//   APB  : device_address at 0x0, command_prefix at 0x4, data_prefix at 0x8;
//          write only while no request is in flight.
// The first byte of a request is registered in the output register after its
//   item has been taken and written into the descriptor queue. Unless the
//   receiver stalls, the sequencer emits one byte per cycle; the requests
//   have init INIT_LENGTH + 2, shift 4, print 8, cursor 5, clear 12 bytes.
//   Back-to-back requests run without gaps while the receiver keeps up.
// Unknown operations are taken and produce no bytes.
// A two-entry descriptor queue lets requests be taken while earlier ones
//   are still being sequenced; when it is full req.ready drops.
// When the receiver stalls, the current byte holds in the output register
//   and sequencing pauses. Reset empties the queue and output and restores
//   the register defaults (address 0x78, command 0x00, data 0x40).
// ----------------------------------------------------------------------------
module oled_command_byte_sequencer_top
	import ocbs_pkg::*;
#(
	parameter int INIT_LENGTH = INIT_LENGTH_DEF,
	parameter int CLEAR_BYTES = CLEAR_BYTES_DEF,
	parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ocbs_stream_if.sink   req,
	ocbs_stream_if.source rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_not_empty;
	desc_t push_desc;
	desc_t head;
	req_t  req_payload;
	rsp_t  rsp_payload;

	assign req_payload = req.data;
	assign rsp.data    = rsp_payload;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= 8'd120;
			cfg_q.command_prefix <= 8'd0;
			cfg_q.data_prefix    <= 8'd64;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEVICE_ADDRESS: cfg_q.device_address <= pwdata[7:0];
				REG_COMMAND_PREFIX: cfg_q.command_prefix <= pwdata[7:0];
				REG_DATA_PREFIX:    cfg_q.data_prefix    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_DEVICE_ADDRESS: prdata = {24'd0, cfg_q.device_address};
			REG_COMMAND_PREFIX: prdata = {24'd0, cfg_q.command_prefix};
			REG_DATA_PREFIX:    prdata = {24'd0, cfg_q.data_prefix};
			default:            prdata = 32'd0;
		endcase
	end

	ocbs_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req_payload),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	ocbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	ocbs_back #(
		.INIT_LENGTH(INIT_LENGTH),
		.CLEAR_BYTES(CLEAR_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_data    (rsp_payload)
	);

endmodule

// ===== hdl/ocbs_front.sv =====
// ----------------------------------------------------------------------------
// ocbs_front - request front end
// Accepts requests, drops unknown operations, maps the character code to a
// glyph index and pushes a compact descriptor into the queue.
// ----------------------------------------------------------------------------
module ocbs_front
	import ocbs_pkg::*;
#(
	parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req_data,
	input  logic  q_full,
	output logic  push,
	output desc_t push_desc
);
	localparam logic [7:0] GLYPH_LIMIT = 8'(GLYPH_COUNT);
	localparam logic [7:0] FONT_LIMIT  = 8'(FONT_SIZE);
	localparam logic [7:0] FIRST_CHAR  = 8'd32;

	logic [7:0] char_off;
	logic       has_glyph;
	logic       known_op;

	// Accept whenever the queue has room
	assign req_ready = !q_full;

	// Map the character to a glyph, blank when outside the font or GLYPH_COUNT
	assign char_off  = req_data.char_code - FIRST_CHAR;
	assign has_glyph = (req_data.char_code >= FIRST_CHAR) && (char_off < GLYPH_LIMIT)
		&& (char_off < FONT_LIMIT);

	// Classify the operation
	always_comb begin
		known_op       = 1'b1;
		push_desc.kind = KIND_INIT;
		case (req_data.operation)
			OP_INIT:   push_desc.kind = KIND_INIT;
			OP_SHIFT:  push_desc.kind = KIND_SHIFT;
			OP_PRINT:  push_desc.kind = KIND_PRINT;
			OP_CURSOR: push_desc.kind = KIND_CURSOR;
			OP_CLEAR:  push_desc.kind = KIND_CLEAR;
			default:   known_op = 1'b0;
		endcase
		push_desc.glyph  = has_glyph ? char_off[5:0] : 6'd0;
		push_desc.column = req_data.column;
		push_desc.page   = req_data.page;
		push_desc.vshift = req_data.vertical_shift;
	end

	// Drop unknown operations: they are taken but yield nothing
	assign push = req_valid && req_ready && known_op;

endmodule

// ===== hdl/ocbs_queue.sv =====
// ----------------------------------------------------------------------------
// ocbs_queue - descriptor queue
// Short FIFO that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module ocbs_queue
	import ocbs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output desc_t head
);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	desc_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/ocbs_back.sv =====
// ----------------------------------------------------------------------------
// ocbs_back - byte sequencer
// Walks the head descriptor step by step and, unless the receiver stalls,
// emits one item per cycle to an output register; pops on the last byte.
// ----------------------------------------------------------------------------
module ocbs_back
	import ocbs_pkg::*;
#(
	parameter int INIT_LENGTH = INIT_LENGTH_DEF,
	parameter int CLEAR_BYTES = CLEAR_BYTES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_not_empty,
	input  desc_t head,
	output logic  pop,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp_data
);
	localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_LENGTH + 1);
	localparam logic [9:0]        CLEAR_REPS = 10'(CLEAR_BYTES);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] init_idx;
	logic [STEP_W-1:0] font_idx;
	logic              out_valid_q;
	rsp_t              out_q;
	rsp_t              nxt;
	logic              advance;

	assign init_idx = step_q - STEP_W'(2);
	assign font_idx = step_q - STEP_W'(3);

	// Build the byte for the current step
	always_comb begin
		nxt.out_byte     = 8'h00;
		nxt.start_before = 1'b0;
		nxt.stop_after   = 1'b0;
		nxt.repeat_count = 10'd1;
		nxt.last         = 1'b0;
		case (head.kind)
			KIND_INIT: begin
				if (step_q == '0) begin
					nxt.out_byte     = cfg.device_address;
					nxt.start_before = 1'b1;
				end else if (step_q == STEP_W'(1)) begin
					nxt.out_byte = cfg.command_prefix;
				end else begin
					nxt.out_byte   = INIT_TABLE[init_idx[4:0]];
					nxt.stop_after = (step_q == INIT_LAST);
					nxt.last       = (step_q == INIT_LAST);
				end
			end
			KIND_SHIFT: begin
				case (step_q)
					STEP_W'(0): begin
						nxt.out_byte     = cfg.device_address;
						nxt.start_before = 1'b1;
					end
					STEP_W'(1): nxt.out_byte = cfg.command_prefix;
					STEP_W'(2): nxt.out_byte = CMD_SET_OFFSET;
					default: begin
						nxt.out_byte   = {2'b00, head.vshift};
						nxt.stop_after = 1'b1;
						nxt.last       = 1'b1;
					end
				endcase
			end
			KIND_PRINT: begin
				case (step_q)
					STEP_W'(0): begin
						nxt.out_byte     = cfg.device_address;
						nxt.start_before = 1'b1;
					end
					STEP_W'(1): nxt.out_byte = cfg.data_prefix;
					STEP_W'(2): nxt.out_byte = 8'h00;
					default: begin
						nxt.out_byte   = font_column(head.glyph, font_idx[2:0]);
						nxt.stop_after = (step_q == STEP_W'(7));
						nxt.last       = (step_q == STEP_W'(7));
					end
				endcase
			end
			KIND_CURSOR: begin
				case (step_q)
					STEP_W'(0): begin
						nxt.out_byte     = cfg.device_address;
						nxt.start_before = 1'b1;
					end
					STEP_W'(1): nxt.out_byte = cfg.command_prefix;
					STEP_W'(2): nxt.out_byte = {1'b0, head.column} & COL_LO_MASK;
					STEP_W'(3): nxt.out_byte = CMD_COL_HI | {5'd0, head.column[6:4]};
					default: begin
						nxt.out_byte   = CMD_PAGE_BASE | {5'd0, head.page};
						nxt.stop_after = 1'b1;
						nxt.last       = 1'b1;
					end
				endcase
			end
			KIND_CLEAR: begin
				case (step_q)
					STEP_W'(0), STEP_W'(5), STEP_W'(8): begin
						nxt.out_byte     = cfg.device_address;
						nxt.start_before = 1'b1;
					end
					STEP_W'(1), STEP_W'(9): nxt.out_byte = cfg.command_prefix;
					STEP_W'(2): nxt.out_byte = 8'h00;
					STEP_W'(3): nxt.out_byte = CMD_COL_HI;
					STEP_W'(4): begin
						nxt.out_byte   = CMD_PAGE_BASE;
						nxt.stop_after = 1'b1;
					end
					STEP_W'(6): nxt.out_byte = cfg.data_prefix;
					STEP_W'(7): begin
						nxt.out_byte     = 8'h00;
						nxt.stop_after   = 1'b1;
						nxt.repeat_count = CLEAR_REPS;
					end
					STEP_W'(10): nxt.out_byte = CMD_SET_OFFSET;
					default: begin
						nxt.out_byte   = 8'h00;
						nxt.stop_after = 1'b1;
						nxt.last       = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	// Load the output register when it is empty or being taken
	assign advance   = !out_valid_q || rsp_ready;
	assign pop       = advance && q_not_empty && nxt.last;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Hold result payload
	always_ff @(posedge clk) begin
		if (advance && q_not_empty) begin
			out_q <= nxt;
		end
	end

	// Advance the step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= q_not_empty;
			if (q_not_empty) begin
				step_q <= nxt.last ? '0 : step_q + 1'b1;
			end
		end
	end

endmodule
